@@ rtl/lsm_pkg.sv @@
// Shared constants and types for the line segment median block.
`timescale 1ns / 1ps
`default_nettype none
package lsm_pkg;

  localparam int unsigned MAX_SEGMENTS = 16;
  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } point_t;

  // Write request into one point store.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    point_t           data;
  } store_wr_t;

endpackage
`default_nettype wire

@@ rtl/lsm_store.sv @@
// Point store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lsm_store (
  input  wire logic                    clk_i,
  input  wire lsm_pkg::store_wr_t      wr_i,
  input  wire logic [lsm_pkg::IDX_W-1:0] raddr_i,
  output lsm_pkg::point_t              rdata_o
);

  lsm_pkg::point_t mem [lsm_pkg::MAX_SEGMENTS];
  lsm_pkg::point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/lsm_unit.sv @@
// Shared compare and halved-sum unit for sort passes and the median.
`timescale 1ns / 1ps
`default_nettype none
module lsm_unit (
  input  wire lsm_pkg::point_t a_i,
  input  wire lsm_pkg::point_t b_i,
  output logic                 b_lt_a_o,
  output lsm_pkg::point_t      mid_o
);

  logic [lsm_pkg::COORD_BITS:0] sum_x;
  logic [lsm_pkg::COORD_BITS:0] sum_y;

  assign b_lt_a_o = (b_i.x < a_i.x);
  assign sum_x    = {1'b0, a_i.x} + {1'b0, b_i.x};
  assign sum_y    = {1'b0, a_i.y} + {1'b0, b_i.y};
  // floor of half the sum: drop the low bit
  assign mid_o.x  = sum_x[lsm_pkg::COORD_BITS:1];
  assign mid_o.y  = sum_y[lsm_pkg::COORD_BITS:1];

endmodule
`default_nettype wire

@@ rtl/line_segment_median.sv @@
// Top level: segment collection, bubble-sort sequencer and median output.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: start_x, start_y, end_x, end_y;
//                                               tlast: last_segment
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: median_start_x, median_start_y,
//                                               median_end_x, median_end_y,
//                                               segments_used, overflow
//
// A segment without tlast is stored while the block stays idle. A marked
// segment starts the sort (a single stored segment goes straight to the
// median): each store (start, then end) runs bubble passes on x through the
// single store read port and the shared compare unit, until a pass makes no
// swap; then the median runs its address, load, start and end steps.
// Reset clears the sequencer, the count, the drop flag and the output valid;
// store contents need no reset. A pending result stalls only the final
// median step; no segments are taken while that step waits.
module line_segment_median (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [11:0] start_x, [23:12] start_y, [35:24] end_x, [47:36] end_y
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [11:0] median_start_x, [23:12] median_start_y, [35:24] median_end_x,
  // [47:36] median_end_y, [52:48] segments_used, [53] overflow, [55:54] zero
  output logic [55:0]      m_axis_tdata
);

  localparam int unsigned CW = lsm_pkg::COORD_BITS;
  localparam int unsigned IW = lsm_pkg::IDX_W;
  localparam int unsigned NW = lsm_pkg::CNT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_FIRST = 4'd2;
  localparam logic [3:0] S_STEP  = 4'd3;
  localparam logic [3:0] S_LAST  = 4'd4;
  localparam logic [3:0] S_MRD0  = 4'd5;
  localparam logic [3:0] S_MRD1  = 4'd6;
  localparam logic [3:0] S_MS    = 4'd7;
  localparam logic [3:0] S_ME    = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            drop_q, drop_d;
  logic [IW-1:0]   j_q, j_d;
  logic            sel_q, sel_d;      // 0 sorts start store, 1 sorts end store
  logic            swapped_q, swapped_d;
  lsm_pkg::point_t cur_q, cur_d;      // element carried along a pass
  lsm_pkg::point_t a_start_q, a_start_d;
  lsm_pkg::point_t a_end_q, a_end_d;
  lsm_pkg::point_t res_start_q, res_start_d;

  logic            out_valid_q, out_valid_d;
  lsm_pkg::point_t out_start_q, out_start_d;
  lsm_pkg::point_t out_end_q, out_end_d;
  logic [NW-1:0]   out_cnt_q, out_cnt_d;
  logic            out_ovf_q, out_ovf_d;

  lsm_pkg::store_wr_t wr_start, wr_end;
  logic [IW-1:0]      raddr;
  lsm_pkg::point_t    rd_start, rd_end, rd_sel;
  lsm_pkg::point_t    sort_wdata;
  logic               sort_we;
  logic [IW-1:0]      sort_waddr;

  lsm_pkg::point_t    unit_a, unit_b, unit_mid;
  logic               unit_lt;

  lsm_pkg::point_t    in_start, in_end;
  logic               in_xfer;
  logic               out_free;
  logic [NW-1:0]      half_cnt;
  logic [NW-1:0]      j_plus2;

  assign in_start.x = s_axis_tdata[CW-1:0];
  assign in_start.y = s_axis_tdata[2*CW-1:CW];
  assign in_end.x   = s_axis_tdata[3*CW-1:2*CW];
  assign in_end.y   = s_axis_tdata[4*CW-1:3*CW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign half_cnt      = cnt_q >> 1;
  assign j_plus2       = NW'(j_q) + NW'(2);
  assign rd_sel        = sel_q ? rd_end : rd_start;

  // Store write ports: input segments while idle, pass write-back otherwise.
  always_comb begin
    wr_start.we   = 1'b0;
    wr_start.addr = cnt_q[IW-1:0];
    wr_start.data = in_start;
    wr_end.we     = 1'b0;
    wr_end.addr   = cnt_q[IW-1:0];
    wr_end.data   = in_end;
    if (state_q == S_IDLE) begin
      wr_start.we = in_xfer && (cnt_q < NW'(lsm_pkg::MAX_SEGMENTS));
      wr_end.we   = wr_start.we;
    end else begin
      wr_start.we   = sort_we && !sel_q;
      wr_start.addr = sort_waddr;
      wr_start.data = sort_wdata;
      wr_end.we     = sort_we && sel_q;
      wr_end.addr   = sort_waddr;
      wr_end.data   = sort_wdata;
    end
  end

  lsm_store u_start_store (
    .clk_i   (clk_i),
    .wr_i    (wr_start),
    .raddr_i (raddr),
    .rdata_o (rd_start)
  );

  lsm_store u_end_store (
    .clk_i   (clk_i),
    .wr_i    (wr_end),
    .raddr_i (raddr),
    .rdata_o (rd_end)
  );

  // Shared unit: compare during passes, halved sum during the median.
  always_comb begin
    unit_a = cur_q;
    unit_b = rd_sel;
    if (state_q == S_MS) begin
      unit_a = a_start_q;
      unit_b = rd_start;
    end else if (state_q == S_ME) begin
      unit_a = a_end_q;
      unit_b = rd_end;
    end
  end

  lsm_unit u_unit (
    .a_i      (unit_a),
    .b_i      (unit_b),
    .b_lt_a_o (unit_lt),
    .mid_o    (unit_mid)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    j_d         = j_q;
    sel_d       = sel_q;
    swapped_d   = swapped_q;
    cur_d       = cur_q;
    a_start_d   = a_start_q;
    a_end_d     = a_end_q;
    res_start_d = res_start_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;
    out_cnt_d   = out_cnt_q;
    out_ovf_d   = out_ovf_q;
    raddr       = half_cnt[IW-1:0];
    sort_we     = 1'b0;
    sort_waddr  = j_q;
    sort_wdata  = cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (cnt_q < NW'(lsm_pkg::MAX_SEGMENTS)) begin
            cnt_d = cnt_q + NW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast) begin
            sel_d = 1'b0;
            // a single stored segment is already sorted
            state_d = (cnt_d == NW'(1)) ? S_MRD0 : S_INIT;
          end
        end
      end
      S_INIT: begin
        raddr     = '0;
        swapped_d = 1'b0;
        j_d       = '0;
        state_d   = S_FIRST;
      end
      S_FIRST: begin
        cur_d   = rd_sel;
        raddr   = IW'(1);
        state_d = S_STEP;
      end
      S_STEP: begin
        // keep the larger x in hand, write the smaller back at j
        sort_we    = 1'b1;
        sort_wdata = unit_lt ? rd_sel : cur_q;
        cur_d      = unit_lt ? cur_q : rd_sel;
        swapped_d  = swapped_q || unit_lt;
        raddr      = j_plus2[IW-1:0];
        if (j_plus2 == cnt_q) begin
          state_d = S_LAST;
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      S_LAST: begin
        sort_we    = 1'b1;
        sort_waddr = IW'(cnt_q - NW'(1));
        sort_wdata = cur_q;
        if (swapped_q) begin
          state_d = S_INIT;
        end else if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = S_INIT;
        end else begin
          state_d = S_MRD0;
        end
      end
      S_MRD0: begin
        // odd count: read the middle twice, halved sum gives it back
        raddr   = cnt_q[0] ? half_cnt[IW-1:0] : IW'(half_cnt - NW'(1));
        state_d = S_MRD1;
      end
      S_MRD1: begin
        a_start_d = rd_start;
        a_end_d   = rd_end;
        state_d   = S_MS;
      end
      S_MS: begin
        res_start_d = unit_mid;
        state_d     = S_ME;
      end
      S_ME: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          out_start_d = res_start_q;
          out_end_d   = unit_mid;
          out_cnt_d   = cnt_q;
          out_ovf_d   = drop_q;
          cnt_d       = '0;
          drop_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
      swapped_q   <= 1'b0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
      swapped_q   <= swapped_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    a_start_q   <= a_start_d;
    a_end_q     <= a_end_d;
    res_start_q <= res_start_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
    out_cnt_q   <= out_cnt_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_ovf_q, 5'(out_cnt_q),
                          out_end_q.y, out_end_q.x, out_start_q.y, out_start_q.x};

  // Count never passes capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NW'(lsm_pkg::MAX_SEGMENTS))
    else $error("stored count beyond capacity");

  // A compare step always reads an entry inside the stored set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (j_plus2 <= cnt_q))
    else $error("pass index past stored count");

  // A new result always carries at least one segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ME && out_free) |=> (m_axis_tvalid && m_axis_tdata[52:48] != 5'd0))
    else $error("result missing or empty");

  // Sorting and median only run on a non-empty set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (cnt_q != '0))
    else $error("sequencer busy with empty set");

endmodule
`default_nettype wire
